@@ design/slcfr_pkg.sv @@
// slcfr_pkg: shared types and constants for the sync/length/checksum frame receiver.
// No dependencies; used by every module in design/ except slcfr_ram.
package slcfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 16;
	localparam int BYTE_W          = 8;
	localparam int TICK_W          = 16;
	localparam int POS_W           = 4;
	localparam int STAT_W          = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUM_SEED    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd3;

	localparam logic [BYTE_W-1:0] RST_FIRST_SYNC  = 8'hA3;
	localparam logic [BYTE_W-1:0] RST_SECOND_SYNC = 8'hFA;
	localparam logic [BYTE_W-1:0] RST_SUM_SEED    = 8'h9D;
	localparam logic [TICK_W-1:0] RST_TIMEOUT     = 16'd360;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [STAT_W-1:0] ST_GOOD     = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

	typedef enum logic [2:0] {
		PH_SYNC0,
		PH_SYNC1,
		PH_LEN,
		PH_DATA,
		PH_CHECK
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] first_sync;
		logic [BYTE_W-1:0] second_sync;
		logic [BYTE_W-1:0] sum_seed;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_t;

	// parser -> drain: one-cycle command at the checksum beat
	typedef struct packed {
		logic              start_run;
		logic              single;
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] count;
	} cmd_t;

	// drain -> parser
	typedef struct packed {
		logic busy;
		logic out_free;
	} drain_stat_t;

endpackage

@@ design/slcfr_ram.sv @@
// slcfr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module slcfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/slcfr_parser.sv @@
// slcfr_parser: frame hunt state machine, tick timer, checksum and payload store writes.
// Depends on slcfr_pkg; issues run commands to slcfr_drain.
module slcfr_parser import slcfr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [BYTE_W-1:0] rx_byte,
	input  cfg_t              cfg,
	input  drain_stat_t       dstat,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [BYTE_W-1:0] ram_wdata,
	output cmd_t              cmd
);

	localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

	phase_t            phase_q, phase_d, eff_phase;
	logic [BYTE_W-1:0] bytes_left_q;
	logic [AW-1:0]     widx_q;
	logic [BYTE_W-1:0] frame_len_q;
	logic [BYTE_W-1:0] sum_q;
	logic [TICK_W-1:0] elapsed_q;
	logic              accept, is_byte, timed_out, sum_ok;

	assign in_ready  = !dstat.busy && (phase_q != PH_CHECK || dstat.out_free);
	assign accept    = in_valid && in_ready;
	assign is_byte   = accept && (operation == OP_BYTE);
	assign timed_out = (phase_q != PH_SYNC0) && (elapsed_q > cfg.timeout_ticks);
	assign eff_phase = timed_out ? PH_SYNC0 : phase_q;
	assign sum_ok    = BYTE_W'(cfg.sum_seed + sum_q) == rx_byte;

	// next state
	always_comb begin
		phase_d = phase_q;
		if (is_byte) begin
			unique case (eff_phase)
				PH_SYNC0: phase_d = (rx_byte == cfg.first_sync) ? PH_SYNC1 : PH_SYNC0;
				PH_SYNC1: phase_d = (rx_byte == cfg.second_sync) ? PH_LEN : PH_SYNC0;
				PH_LEN: begin
					if (rx_byte > MAX_LEN) begin
						phase_d = PH_SYNC0;
					end else if (rx_byte == '0) begin
						phase_d = PH_CHECK;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA:  phase_d = (bytes_left_q <= BYTE_W'(1)) ? PH_CHECK : PH_DATA;
				PH_CHECK: phase_d = PH_SYNC0;
				default:  phase_d = PH_SYNC0;
			endcase
		end
	end

	// outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = widx_q;
		ram_wdata = rx_byte;
		cmd       = '0;
		if (is_byte) begin
			unique case (eff_phase)
				PH_DATA: ram_we = 1'b1;
				PH_CHECK: begin
					if (!sum_ok) begin
						cmd.single = 1'b1;
						cmd.status = ST_MISMATCH;
					end else if (frame_len_q == '0) begin
						cmd.single = 1'b1;
						cmd.status = ST_EMPTY;
					end else begin
						cmd.start_run = 1'b1;
						cmd.status    = ST_GOOD;
						cmd.count     = frame_len_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SYNC0;
			bytes_left_q <= '0;
			widx_q       <= '0;
			frame_len_q  <= '0;
			sum_q        <= '0;
			elapsed_q    <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept && operation == OP_TICK) begin
				if (elapsed_q != '1) begin
					elapsed_q <= elapsed_q + 1'b1;
				end
			end
			if (is_byte) begin
				if (timed_out) begin
					bytes_left_q <= '0;
					widx_q       <= '0;
				end
				unique case (eff_phase)
					PH_SYNC0: begin
						if (rx_byte == cfg.first_sync) begin
							elapsed_q <= '0;
						end
					end
					PH_LEN: begin
						if (rx_byte > MAX_LEN) begin
							bytes_left_q <= '0;
						end else begin
							frame_len_q  <= rx_byte;
							bytes_left_q <= rx_byte;
							sum_q        <= rx_byte;
						end
						widx_q <= '0;
					end
					PH_DATA: begin
						widx_q <= widx_q + 1'b1;
						sum_q  <= sum_q + rx_byte;
						if (bytes_left_q != '0) begin
							bytes_left_q <= bytes_left_q - 1'b1;
						end
					end
					PH_CHECK: begin
						bytes_left_q <= '0;
						widx_q       <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> !accept)
		else $error("input beat accepted during drain");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_len_q <= MAX_LEN)
		else $error("frame length above maximum");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (phase_q == PH_DATA) && (bytes_left_q != '0))
		else $error("payload write outside data phase");

endmodule

@@ design/slcfr_drain.sv @@
// slcfr_drain: reads the payload store and drives the result register.
// Depends on slcfr_pkg; reads through slcfr_ram.
module slcfr_drain import slcfr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output drain_stat_t       dstat,
	output logic              ram_re,
	output logic [AW-1:0]     ram_raddr,
	input  logic [BYTE_W-1:0] ram_rdata,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] data,
	output logic [POS_W-1:0]  position,
	output logic              last,
	output logic [STAT_W-1:0] status
);

	logic              issuing_q, s1_valid_q;
	logic [BYTE_W-1:0] rd_idx_q, cnt_q, rd_next;
	logic [BYTE_W-1:0] pos_s1;
	logic              last_s1;
	logic              out_valid_q, last_q;
	logic [BYTE_W-1:0] data_q;
	logic [POS_W-1:0]  pos_q;
	logic [STAT_W-1:0] status_q;
	logic              out_free, s1_move, issue;

	assign out_free   = !out_valid_q || out_ready;
	assign s1_move    = s1_valid_q && out_free;
	assign issue      = issuing_q && (!s1_valid_q || s1_move);
	assign rd_next    = rd_idx_q + 1'b1;
	assign ram_re     = issue;
	assign ram_raddr  = rd_idx_q[AW-1:0];
	assign dstat.busy     = issuing_q || s1_valid_q;
	assign dstat.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q   <= 1'b0;
			s1_valid_q  <= 1'b0;
			rd_idx_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start_run) begin
				issuing_q <= 1'b1;
				rd_idx_q  <= '0;
				cnt_q     <= cmd.count;
			end else if (issue) begin
				rd_idx_q <= rd_next;
				if (rd_next == cnt_q) begin
					issuing_q <= 1'b0;
				end
			end
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (cmd.single || s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1  <= rd_idx_q;
			last_s1 <= (rd_next == cnt_q);
		end
		if (cmd.single) begin
			data_q   <= '0;
			pos_q    <= '0;
			last_q   <= 1'b1;
			status_q <= cmd.status;
		end else if (s1_move) begin
			data_q   <= ram_rdata;
			pos_q    <= POS_W'(pos_s1);
			last_q   <= last_s1;
			status_q <= ST_GOOD;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign position  = pos_q;
	assign last      = last_q;
	assign status    = status_q;

	a_single_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.single |-> !issuing_q && !s1_valid_q && out_free)
		else $error("status result while drain active or output full");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> rd_idx_q < cnt_q)
		else $error("store read past frame length");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_run |-> !issuing_q && !s1_valid_q)
		else $error("run started while previous run active");

endmodule

@@ design/sync_length_checksum_frame_receiver.sv @@
// sync_length_checksum_frame_receiver: top level, configuration registers and wiring.
// Depends on slcfr_pkg, slcfr_ram, slcfr_parser, slcfr_drain.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_ready   | operation, rx_byte
//  out     | out_valid / out_ready | data, position, last, status
//  cfg     | cfg_we                | cfg_index, cfg_data
//
// Bytes and ticks are accepted while in_ready is high; a status result reaches the output
// register the cycle after its checksum beat. A good frame of N bytes drains one result
// a cycle from the payload RAM, via its registered read data, to the output register, with
// in_ready low until the last result is in the output register. Output stalls hold
// the drain and a checksum beat. Reset is asynchronous; the payload RAM needs no clearing.
module sync_length_checksum_frame_receiver import slcfr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [BYTE_W-1:0]     rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BYTE_W-1:0]     data,
	output logic [POS_W-1:0]      position,
	output logic                  last,
	output logic [STAT_W-1:0]     status,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	cfg_t              cfg_q;
	drain_stat_t       dstat;
	cmd_t              cmd;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_sync    <= RST_FIRST_SYNC;
			cfg_q.second_sync   <= RST_SECOND_SYNC;
			cfg_q.sum_seed      <= RST_SUM_SEED;
			cfg_q.timeout_ticks <= RST_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_SYNC:  cfg_q.first_sync    <= cfg_data[BYTE_W-1:0];
				CFG_SECOND_SYNC: cfg_q.second_sync   <= cfg_data[BYTE_W-1:0];
				CFG_SUM_SEED:    cfg_q.sum_seed      <= cfg_data[BYTE_W-1:0];
				CFG_TIMEOUT:     cfg_q.timeout_ticks <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	slcfr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.rx_byte   (rx_byte),
		.cfg       (cfg_q),
		.dstat     (dstat),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.cmd       (cmd)
	);

	slcfr_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PAYLOAD)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	slcfr_drain #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.dstat     (dstat),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (data),
		.position  (position),
		.last      (last),
		.status    (status)
	);

endmodule
